[rtl/rti_pkg.sv]
// Shared constants and register index codes for the ray/triangle test.
// No dependencies; used by rti_div and ray_triangle_intersection.
package rti_pkg;

  localparam int OUT_W      = 32;         // width of distance, bary_u, bary_v
  localparam int MARGIN_W   = 16;         // edge margin, unsigned Q0.16
  localparam int UNIT_SHIFT = 16;         // 1.0 in the margin's Q0.16 scale
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int DIV_LAT    = OUT_W + 2;  // divider: setup, one stage per bit, clamp

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_CULL     = 3'd6,
    REG_MARGIN   = 3'd7
  } reg_idx_t;

endpackage

[rtl/rti_div.sv]
// Pipelined restoring divider: round(mag * 2^FRAC_BITS / den), ties away
// from zero, saturated and signed. Depends on rti_pkg.
module rti_div #(
  parameter int NUM_W     = 102,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [NUM_W-1:0]                  den_i,
  input  logic [NUM_W-1:0]                  mag_i,
  input  logic                              neg_i,
  output logic signed [rti_pkg::OUT_W-1:0]  res_o
);

  localparam int QB = rti_pkg::OUT_W;
  localparam int RW = NUM_W + FRAC_BITS + QB + 2;

  logic [RW-1:0] rem_r [QB+1];
  logic [RW-1:0] dv_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          neg_r [QB+1];
  logic [QB-1:0] res_r;
  logic [QB-1:0] lim;
  logic [QB-1:0] mag_q;

  // top = mag * 2^(F+1) + den over 2*den gives the rounded quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (RW'(mag_i) << (FRAC_BITS + 1)) + RW'(den_i);
      dv_r[0]  <= RW'(den_i) << 1;
      q_r[0]   <= '0;
      neg_r[0] <= neg_i;
    end
  end

  for (genvar gi = 0; gi < QB; gi++) begin : g_bit
    logic [RW-1:0] sh;
    logic          take;
    assign sh   = dv_r[gi] << (QB - 1 - gi);
    assign take = rem_r[gi] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi+1] <= take ? rem_r[gi] - sh : rem_r[gi];
        dv_r[gi+1]  <= dv_r[gi];
        q_r[gi+1]   <= {q_r[gi][QB-2:0], take};
        neg_r[gi+1] <= neg_r[gi];
      end
    end
  end

  // an oversized quotient leaves all ones here and clamps like any other
  assign lim   = neg_r[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
  assign mag_q = (q_r[QB] > lim) ? lim : q_r[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= neg_r[QB] ? QB'(0) - mag_q : mag_q;
    end
  end

  assign res_o = $signed(res_r);

endmodule

[rtl/ray_triangle_intersection.sv]
// Moller-Trumbore ray/triangle test, fully pipelined, one triangle per beat.
// Depends on rti_pkg and rti_div.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | in_tdata: a_x a_y a_z b_x .. c_z
//  out_    | out | out_tvalid / out_tready| out_tdata: distance u v; out_tuser: hit
//  cfg_    | in  | APB, pready tied high  | 8 registers at 4*i (8*i if COORD_BITS>32)
//
// The pipeline has 11 arithmetic stages, 34 divider stages and 1 output
// stage; one beat is taken every cycle while the output is drained.
// The three 32-bit quotients set the depth: one quotient bit per stage.
// A stall freezes every stage at once; in_tready follows the output slot.
// Synchronous reset clears the valid pipe and loads register defaults.
module ray_triangle_intersection #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first), zero padded
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // distance, bary_u, bary_v (lowest first)
  output logic [3*rti_pkg::OUT_W-1:0]          out_tdata,
  // hit
  output logic                                 out_tuser,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [$clog2(rti_pkg::NUM_REGS*((COORD_BITS>32)?8:4))-1:0] cfg_paddr,
  input  logic [((COORD_BITS>32)?64:32)-1:0]   cfg_pwdata,
  output logic [((COORD_BITS>32)?64:32)-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int W        = COORD_BITS;
  localparam int EW       = W + 1;          // edges and origin offset
  localparam int XW       = 2 * EW;         // cross-product terms
  localparam int QW       = XW + 1;         // cross products p, q
  localparam int NW       = EW + QW + 2;    // det, U, V, T
  localparam int L        = QW / 2;         // split of p, q for the dot products
  localparam int LPW      = EW + L + 1;
  localparam int HPW      = EW + QW - L;
  localparam int MW       = rti_pkg::MARGIN_W;
  localparam int DL       = NW / 2;         // split of D for the margin product
  localparam int CW       = NW + MW + 2;    // bound comparisons
  localparam int OW       = rti_pkg::OUT_W;
  localparam int CFG_DW   = (W > 32) ? 64 : 32;
  localparam int ADDR_LSB = (W > 32) ? 3 : 2;
  localparam int CFG_AW   = $clog2(rti_pkg::NUM_REGS * ((W > 32) ? 8 : 4));
  localparam int NSTG     = 11;
  localparam int DLAT     = rti_pkg::DIV_LAT;
  localparam int TOT      = NSTG + DLAT + 1;

  // ---------------- configuration ----------------
  logic [W-1:0]      org_r [3];
  logic [W-1:0]      dir_r [3];
  logic              cull_r;
  logic [MW-1:0]     margin_r;
  logic              cfg_wr;
  rti_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = rti_pkg::reg_idx_t'(cfg_paddr[CFG_AW-1:ADDR_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= W'(1) << FRAC_BITS;
      cull_r   <= 1'b0;
      margin_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rti_pkg::REG_ORIGIN_X: org_r[0] <= cfg_pwdata[W-1:0];
        rti_pkg::REG_ORIGIN_Y: org_r[1] <= cfg_pwdata[W-1:0];
        rti_pkg::REG_ORIGIN_Z: org_r[2] <= cfg_pwdata[W-1:0];
        rti_pkg::REG_DIR_X:    dir_r[0] <= cfg_pwdata[W-1:0];
        rti_pkg::REG_DIR_Y:    dir_r[1] <= cfg_pwdata[W-1:0];
        rti_pkg::REG_DIR_Z:    dir_r[2] <= cfg_pwdata[W-1:0];
        rti_pkg::REG_CULL:     cull_r   <= cfg_pwdata[0];
        rti_pkg::REG_MARGIN:   margin_r <= cfg_pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rti_pkg::REG_ORIGIN_X: cfg_prdata = CFG_DW'(org_r[0]);
      rti_pkg::REG_ORIGIN_Y: cfg_prdata = CFG_DW'(org_r[1]);
      rti_pkg::REG_ORIGIN_Z: cfg_prdata = CFG_DW'(org_r[2]);
      rti_pkg::REG_DIR_X:    cfg_prdata = CFG_DW'(dir_r[0]);
      rti_pkg::REG_DIR_Y:    cfg_prdata = CFG_DW'(dir_r[1]);
      rti_pkg::REG_DIR_Z:    cfg_prdata = CFG_DW'(dir_r[2]);
      rti_pkg::REG_CULL:     cfg_prdata = CFG_DW'(cull_r);
      rti_pkg::REG_MARGIN:   cfg_prdata = CFG_DW'(margin_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [TOT-1:0] vld_r;
  logic           adv;

  assign adv        = !vld_r[TOT-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[TOT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOT-2:0], in_tvalid};
    end
  end

  // ---------------- stage 1: edges ----------------
  logic signed [EW-1:0] e1_s1_r [3], e2_s1_r [3], s_s1_r [3];
  logic signed [EW-1:0] sdir    [3];

  for (genvar k = 0; k < 3; k++) begin : g_dir
    assign sdir[k] = EW'($signed(dir_r[k]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e1_s1_r[k] <= EW'($signed(in_tdata[(3+k)*W +: W]))
                    - EW'($signed(in_tdata[k*W +: W]));
        e2_s1_r[k] <= EW'($signed(in_tdata[(6+k)*W +: W]))
                    - EW'($signed(in_tdata[k*W +: W]));
        s_s1_r[k]  <= EW'($signed(org_r[k])) - EW'($signed(in_tdata[k*W +: W]));
      end
    end
  end

  // ---------------- stage 2: cross-product terms ----------------
  // pair 0: dir x e2 (p), pair 1: s x e1 (q)
  logic signed [XW-1:0] xa_r [2][3], xb_r [2][3];
  logic signed [EW-1:0] e1_s2_r [3], e2_s2_r [3], s_s2_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        xa_r[0][k] <= sdir[(k+1)%3] * e2_s1_r[(k+2)%3];
        xb_r[0][k] <= sdir[(k+2)%3] * e2_s1_r[(k+1)%3];
        xa_r[1][k] <= s_s1_r[(k+1)%3] * e1_s1_r[(k+2)%3];
        xb_r[1][k] <= s_s1_r[(k+2)%3] * e1_s1_r[(k+1)%3];
        e1_s2_r[k] <= e1_s1_r[k];
        e2_s2_r[k] <= e2_s1_r[k];
        s_s2_r[k]  <= s_s1_r[k];
      end
    end
  end

  // ---------------- stage 3: cross products ----------------
  logic signed [QW-1:0] p_r [3], q_r [3];
  logic signed [EW-1:0] e1_s3_r [3], e2_s3_r [3], s_s3_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k]     <= QW'(xa_r[0][k]) - QW'(xb_r[0][k]);
        q_r[k]     <= QW'(xa_r[1][k]) - QW'(xb_r[1][k]);
        e1_s3_r[k] <= e1_s2_r[k];
        e2_s3_r[k] <= e2_s2_r[k];
        s_s3_r[k]  <= s_s2_r[k];
      end
    end
  end

  // ---------------- stage 4: dot-product partials ----------------
  // lane 0: det = e1.p, 1: U = s.p, 2: V = dir.q, 3: T = e2.q
  logic signed [EW-1:0]  opa [4][3];
  logic signed [QW-1:0]  opb [4][3];
  logic signed [LPW-1:0] pl_r [4][3];
  logic signed [HPW-1:0] ph_r [4][3];

  for (genvar k = 0; k < 3; k++) begin : g_ops
    assign opa[0][k] = e1_s3_r[k];
    assign opb[0][k] = p_r[k];
    assign opa[1][k] = s_s3_r[k];
    assign opb[1][k] = p_r[k];
    assign opa[2][k] = sdir[k];
    assign opb[2][k] = q_r[k];
    assign opa[3][k] = e2_s3_r[k];
    assign opb[3][k] = q_r[k];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) begin
        for (int k = 0; k < 3; k++) begin
          pl_r[d][k] <= opa[d][k] * $signed({1'b0, opb[d][k][L-1:0]});
          ph_r[d][k] <= opa[d][k] * $signed(opb[d][k][QW-1:L]);
        end
      end
    end
  end

  // ---------------- stage 5: full products ----------------
  logic signed [NW-1:0] pr_r [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) begin
        for (int k = 0; k < 3; k++) begin
          pr_r[d][k] <= (NW'(ph_r[d][k]) <<< L) + NW'(pl_r[d][k]);
        end
      end
    end
  end

  // ---------------- stage 6: dot products ----------------
  logic signed [NW-1:0] sm_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) begin
        sm_r[d] <= pr_r[d][0] + pr_r[d][1] + pr_r[d][2];
      end
    end
  end

  // ---------------- stage 7: fold the determinant sign ----------------
  logic                 det_neg;
  logic signed [NW-1:0] d7_r;
  logic signed [NW-1:0] n7_r [3];   // U, V, T
  logic                 ok7_r;

  assign det_neg = sm_r[0][NW-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      d7_r  <= det_neg ? -sm_r[0] : sm_r[0];
      ok7_r <= (sm_r[0] != '0) && !(cull_r && det_neg);
      for (int i = 0; i < 3; i++) begin
        n7_r[i] <= det_neg ? -sm_r[i+1] : sm_r[i+1];
      end
    end
  end

  // ---------------- stage 8: margin product partials ----------------
  logic [MW+DL-1:0]    mdl_r;
  logic [MW+NW-DL-1:0] mdh_r;
  logic signed [NW-1:0] d8_r, n8_r [3];
  logic                 ok8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mdl_r <= margin_r * d7_r[DL-1:0];
      mdh_r <= margin_r * d7_r[NW-1:DL];
      d8_r  <= d7_r;
      n8_r  <= n7_r;
      ok8_r <= ok7_r;
    end
  end

  // ---------------- stage 9: margin product M*D ----------------
  logic [NW+MW-1:0]     md9_r;
  logic signed [NW-1:0] d9_r, n9_r [3];
  logic                 ok9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      md9_r <= ((NW+MW)'(mdh_r) << DL) + (NW+MW)'(mdl_r);
      d9_r  <= d8_r;
      n9_r  <= n8_r;
      ok9_r <= ok8_r;
    end
  end

  // ---------------- stage 10: bounds and scaled numerators ----------------
  logic signed [CW-1:0] lo10_r, hi10_r, us10_r, vs10_r, uvs10_r;
  logic signed [NW-1:0] d10_r, n10_r [3];
  logic                 ok10_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      lo10_r  <= -$signed(CW'(md9_r));
      hi10_r  <= (CW'(d9_r) <<< rti_pkg::UNIT_SHIFT) + $signed(CW'(md9_r));
      us10_r  <= CW'(n9_r[0]) <<< rti_pkg::UNIT_SHIFT;
      vs10_r  <= CW'(n9_r[1]) <<< rti_pkg::UNIT_SHIFT;
      uvs10_r <= (CW'(n9_r[0]) + CW'(n9_r[1])) <<< rti_pkg::UNIT_SHIFT;
      d10_r   <= d9_r;
      n10_r   <= n9_r;
      ok10_r  <= ok9_r;
    end
  end

  // ---------------- stage 11: hit decision, magnitudes ----------------
  logic            hit11_r;
  logic [NW-1:0]   d11_r;
  logic [NW-1:0]   mag11_r [3];   // T, U, V order for distance, u, v
  logic            sg11_r  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      hit11_r <= ok10_r && (us10_r >= lo10_r) && (us10_r <= hi10_r)
              && (vs10_r >= lo10_r) && (uvs10_r <= hi10_r);
      d11_r   <= d10_r;
      for (int i = 0; i < 3; i++) begin
        sg11_r[i]  <= n10_r[(i+2)%3][NW-1];
        mag11_r[i] <= n10_r[(i+2)%3][NW-1] ? -n10_r[(i+2)%3] : n10_r[(i+2)%3];
      end
    end
  end

  // ---------------- dividers ----------------
  logic signed [OW-1:0] res [3];
  logic [DLAT-1:0]      hd_r;

  for (genvar i = 0; i < 3; i++) begin : g_div
    rti_div #(
      .NUM_W     (NW),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .en    (adv),
      .den_i (d11_r),
      .mag_i (mag11_r[i]),
      .neg_i (sg11_r[i]),
      .res_o (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hd_r <= {hd_r[DLAT-2:0], hit11_r};
    end
  end

  // ---------------- output register ----------------
  logic          out_hit_r;
  logic [OW-1:0] out_d_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= hd_r[DLAT-1];
      for (int i = 0; i < 3; i++) begin
        out_d_r[i] <= hd_r[DLAT-1] ? res[i] : '0;   // drop values on a miss
      end
    end
  end

  assign out_tuser = out_hit_r;
  assign out_tdata = {out_d_r[2], out_d_r[1], out_d_r[0]};

  // ---------------- assertions ----------------
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss beat carries nonzero payload");

  a_det_pos: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] && ok7_r |-> !d7_r[NW-1] && d7_r != '0)
    else $error("accepted determinant not strictly positive");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid pipe moved during stall");

  // only meaningful right after an advance; a stall holds both registers
  a_hit_okdet: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[10] && hit11_r && $past(adv) |-> $past(ok10_r))
    else $error("hit without usable determinant");

endmodule

[tb/tb_ray_triangle_intersection.sv]
// Self-checking testbench for ray_triangle_intersection: streams triangles against a
// configurable ray and checks hit, distance and barycentrics against an exact predictor.
// Depends on rti_pkg and the RTL of ray_triangle_intersection.
`timescale 1ns / 1ps

module tb_ray_triangle_intersection;

  typedef logic signed [31:0]  coord_t;
  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic   hit;
    coord_t distance;
    coord_t u;
    coord_t v;
  } hit_result_t;

  class hit_scoreboard;
    coord_t        org[3];
    coord_t        dir[3];
    logic          cull;
    logic [15:0]   margin;
    int            fails;
    hit_result_t   expected_q[$];

    function new();
      org = '{0, 0, 0};
      dir = '{0, 0, 65536};
      cull = 1'b0;
      margin = '0;
      fails = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    function void set_reg(rti_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        rti_pkg::REG_ORIGIN_X: org[0] = val;
        rti_pkg::REG_ORIGIN_Y: org[1] = val;
        rti_pkg::REG_ORIGIN_Z: org[2] = val;
        rti_pkg::REG_DIR_X:    dir[0] = val;
        rti_pkg::REG_DIR_Y:    dir[1] = val;
        rti_pkg::REG_DIR_Z:    dir[2] = val;
        rti_pkg::REG_CULL:     cull = val[0];
        rti_pkg::REG_MARGIN:   margin = val[15:0];
        default: ;
      endcase
    endfunction

    // round(n * 2^16 / d) with ties away from zero, saturated to 32 bits; d > 0
    function coord_t scaled_ratio(wide_t n, wide_t d);
      logic  neg;
      wide_t mag, qt, lim, r;
      neg = n < 0;
      mag = neg ? -n : n;
      qt = (mag * wide_t'(131072) + d) / (d + d);
      lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
      if (qt > lim) qt = lim;
      r = neg ? -qt : qt;
      return r[31:0];
    endfunction

    function hit_result_t predict(coord_t t[9]);
      wide_t a[3], e1[3], e2[3], s[3], dw[3], p[3], q[3];
      wide_t det, un, vn, tn, lo, hi, mw, unit;
      hit_result_t r;
      for (int i = 0; i < 3; i++) begin
        a[i]  = t[i];
        e1[i] = wide_t'(t[3+i]) - a[i];
        e2[i] = wide_t'(t[6+i]) - a[i];
        s[i]  = wide_t'(org[i]) - a[i];
        dw[i] = dir[i];
      end
      p[0] = dw[1]*e2[2] - dw[2]*e2[1];
      p[1] = dw[2]*e2[0] - dw[0]*e2[2];
      p[2] = dw[0]*e2[1] - dw[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
      un  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
      vn  = dw[0]*q[0] + dw[1]*q[1] + dw[2]*q[2];
      tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      r = '{1'b0, 0, 0, 0};
      if (det == 0) return r;
      if (det < 0) begin
        if (cull) return r;
        det = -det; un = -un; vn = -vn; tn = -tn;
      end
      mw = {176'b0, margin};
      unit = 65536;
      lo = -(mw * det);
      hi = (unit + mw) * det;
      if (un*unit < lo || un*unit > hi || vn*unit < lo || (un + vn)*unit > hi) return r;
      r.hit      = 1'b1;
      r.distance = scaled_ratio(tn, det);
      r.u        = scaled_ratio(un, det);
      r.v        = scaled_ratio(vn, det);
      return r;
    endfunction

    function void note_triangle(coord_t t[9]);
      expected_q = {expected_q, predict(t)};
    endfunction

    task check_result(logic hit, coord_t distance, coord_t u, coord_t v);
      hit_result_t e;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (hit !== e.hit) report($sformatf("hit %0b, want %0b", hit, e.hit));
      if (distance !== e.distance)
        report($sformatf("distance %h, want %h", distance, e.distance));
      if (u !== e.u) report($sformatf("bary_u %h, want %h", u, e.u));
      if (v !== e.v) report($sformatf("bary_v %h, want %h", v, e.v));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;   // a_x a_y a_z b_x b_y b_z c_x c_y c_z, lowest first
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;       // distance, bary_u, bary_v, lowest first
  logic         out_tuser;       // hit
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  hit_scoreboard sb = new();
  int send_idle = 38;
  int recv_idle = 85;

  ray_triangle_intersection u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // drain results with random back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64]);
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(rti_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_triangle(coord_t t[9]);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) in_tdata[32*i +: 32] <= t[i];
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_triangle(t);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_ray(coord_t o[3], coord_t d[3], logic cull, logic [15:0] m);
    write_reg(rti_pkg::REG_ORIGIN_X, o[0]); write_reg(rti_pkg::REG_ORIGIN_Y, o[1]);
    write_reg(rti_pkg::REG_ORIGIN_Z, o[2]); write_reg(rti_pkg::REG_DIR_X, d[0]);
    write_reg(rti_pkg::REG_DIR_Y, d[1]);    write_reg(rti_pkg::REG_DIR_Z, d[2]);
    write_reg(rti_pkg::REG_CULL, {31'b0, cull});
    write_reg(rti_pkg::REG_MARGIN, {16'b0, m});
  endtask

  function automatic coord_t near_offset(int span);
    return $signed($urandom_range(2*span)) - span;
  endfunction

  // mostly triangles straddling the ray, the rest full-range noise or degenerate
  task automatic random_phase(int count, int span);
    coord_t t[9];
    logic signed [63:0] k, pt;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        k = $urandom_range(4*65536);
        for (int i = 0; i < 3; i++) begin
          pt = 64'(sb.org[i]) + ((64'(sb.dir[i]) * k) >>> 16);
          for (int j = 0; j < 3; j++) t[3*j+i] = coord_t'(pt) + near_offset(span);
        end
      end else if (kind < 85) begin
        for (int i = 0; i < 9; i++) t[i] = $urandom;
      end else begin
        for (int i = 0; i < 3; i++) begin
          t[i] = near_offset(span);
          t[3+i] = ($urandom_range(1)) ? t[i] : near_offset(span);
          t[6+i] = t[i] + (t[3+i] - t[i]) * 2;   // collinear or point
        end
      end
      send_triangle(t);
    end
  endtask

  localparam coord_t ONE = 65536;
  localparam coord_t MAXC = 32'h7fff_ffff;
  localparam coord_t MINC = 32'h8000_0000;

  initial begin
    coord_t o[3], d[3];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset ray: origin 0, direction +z
    send_triangle('{-ONE, -ONE, ONE,  ONE, -ONE, ONE,  0, ONE, ONE});   // hit
    send_triangle('{-ONE, -ONE, ONE,  0, ONE, ONE,  ONE, -ONE, ONE});   // reversed winding, positive det
    send_triangle('{ONE, ONE, ONE,  ONE, ONE, ONE,  ONE, ONE, ONE});    // zero det
    send_triangle('{-ONE, -ONE, -ONE,  ONE, -ONE, -ONE,  0, ONE, -ONE}); // behind origin
    send_triangle('{0, 0, ONE,  ONE, 0, ONE,  0, ONE, ONE});            // on a vertex
    send_triangle('{1, 0, ONE,  ONE, 0, ONE,  1, ONE, ONE});            // just outside
    send_triangle('{MAXC, MAXC, MAXC,  MINC, MINC, MINC,  MAXC, MINC, MAXC});
    send_triangle('{MINC, MAXC, MINC,  MAXC, MINC, MAXC,  MINC, MINC, MAXC});
    send_triangle('{-1, -1, 1,  1, -1, 1,  0, 1, 1});                   // tiny, t close to zero
    send_triangle('{0, 0, 0,  0, 0, 0,  0, 0, 0});
    wait_drained();
    write_reg(rti_pkg::REG_CULL, 32'd1);
    write_reg(rti_pkg::REG_MARGIN, 32'hffff);
    send_triangle('{-ONE, -ONE, ONE,  0, ONE, ONE,  ONE, -ONE, ONE});   // positive det, not culled
    send_triangle('{1, 0, ONE,  ONE, 0, ONE,  1, ONE, ONE});            // inside margin, but culled (negative det)
    send_triangle('{-ONE, -ONE, ONE,  ONE, -ONE, ONE,  0, ONE, ONE});
    wait_drained();

    for (int i = 0; i < 3; i++) begin
      o[i] = near_offset(1 << 20);
      d[i] = near_offset(1 << 17);
    end
    set_ray(o, d, 1'b1, 16'($urandom));
    random_phase(133, 1 << 17);
    wait_drained();

    send_idle = 85; recv_idle = 38;
    o = '{MINC, MAXC, 0};
    d = '{MAXC, MINC, 1};
    set_ray(o, d, 1'b0, 16'hffff);
    random_phase(133, 1 << 20);
    wait_drained();

    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = near_offset(1 << 22);
      d[i] = near_offset(1 << 16);
    end
    set_ray(o, d, 1'b0, 16'h0000);
    random_phase(134, 1 << 16);
    wait_drained();

    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
